FILE: design/gasa_pkg.sv
// Shared types and constants for the glyph atlas shelf allocator.
`timescale 1ns / 1ps
`default_nettype none

package gasa_pkg;

    // Coordinates and sizes inside an atlas (up to 1024 inclusive).
    localparam int COORD_W = 11;
    // Padded glyph size (up to 256).
    localparam int SIZE_W  = 9;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CHECK
    } gasa_state_t;

    // Per-atlas packing state held in the state memory.
    typedef struct packed {
        logic [COORD_W-1:0] shelf_x;
        logic [COORD_W-1:0] shelf_y;
        logic [COORD_W-1:0] shelf_room_w;
        logic [COORD_W-1:0] shelf_room_h;
        logic [COORD_W-1:0] below_y;
        logic [COORD_W-1:0] below_room_h;
    } atlas_entry_t;

endpackage

`default_nettype wire

FILE: design/glyph_atlas_shelf_allocator.sv
// Top level of the glyph atlas shelf allocator: request handling and atlas state memory.
`timescale 1ns / 1ps
`default_nettype none

// The block packs glyph rectangles into ATLAS_COUNT texture atlases with a
// shelf scheme. Each request carries a glyph's width and height; the glyph is
// padded by one pixel to the right and below and the atlases are tried in
// order, first fit. An empty atlas takes the glyph at its origin; a used atlas
// first tries its current shelf and then opens a new shelf at column 0 from
// the vertical remainder below all earlier glyphs. The result item gives a
// placed flag (in tuser), the atlas index and the top-left position; when
// nothing fits, or the glyph is larger than an atlas, placed is low and the
// other fields are zero. A request with the clear flag set empties every atlas
// and returns a zero result. The per-atlas frontiers live in a small
// synchronous memory with a single registered read port; only the
// "atlas in use" bits sit in flip-flops, so a clear takes effect at once and
// no clearing pass is needed after reset. Timing: an item is taken in
// ST_IDLE and then the atlases are visited in turn in ST_CHECK, the state
// memory being read once per atlas; a finished request waits in ST_CHECK
// while the output register still holds an untaken result. The block works
// on one item at a time; an output register holds a finished result, and a
// new item is accepted while that result still waits to be taken.

module glyph_atlas_shelf_allocator #(
    parameter int ATLAS_COUNT  = 2,
    parameter int ATLAS_WIDTH  = 512,
    parameter int ATLAS_HEIGHT = 512
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Request stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: glyph_width [7:0], glyph_height [15:8]
    input  wire logic [gasa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: cmd (0 place, 1 clear)
    input  wire logic                               s_axis_tuser,
    // Result stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: atlas_index [2:0], pos_x [12:3], pos_y [22:13], zero [23]
    output logic [gasa_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // tuser: placed
    output logic                                    m_axis_tuser
);

    localparam int AW = (ATLAS_COUNT > 1) ? $clog2(ATLAS_COUNT) : 1;
    localparam int CW = gasa_pkg::COORD_W;
    localparam logic [CW-1:0] ATLAS_W_C = CW'(ATLAS_WIDTH);
    localparam logic [CW-1:0] ATLAS_H_C = CW'(ATLAS_HEIGHT);
    localparam logic [AW-1:0] LAST_ATLAS = AW'(ATLAS_COUNT - 1);

    // Control and request registers.
    gasa_pkg::gasa_state_t state_reg, state_next;
    logic [AW-1:0]           atlas_reg, atlas_next;
    logic [ATLAS_COUNT-1:0]  used_reg, used_next;
    logic                    clear_reg, clear_next;
    logic                    reject_reg, reject_next;
    logic [CW-1:0]           pw_reg, pw_next;
    logic [CW-1:0]           ph_reg, ph_next;

    // Output register.
    logic                                out_valid_reg, out_valid_next;
    logic [gasa_pkg::OUT_DATA_W-1:0]     out_data_reg, out_data_next;
    logic                                out_placed_reg, out_placed_next;

    // Atlas state memory.
    gasa_pkg::atlas_entry_t state_mem [ATLAS_COUNT];
    gasa_pkg::atlas_entry_t rd_data_reg;
    gasa_pkg::atlas_entry_t wr_data;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;

    // Decode of the request at the input.
    logic [CW-1:0] in_pw;
    logic [CW-1:0] in_ph;

    // Fit evaluation for the atlas being visited.
    gasa_pkg::atlas_entry_t cur;
    logic          atlas_used;
    logic          shelf_fit;
    logic          below_fit;
    logic [CW-1:0] bottom;
    logic [CW-1:0] delta;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_y;
    logic          fits;
    logic          can_finish;

    assign in_pw = CW'(s_axis_tdata[7:0]) + CW'(1);
    assign in_ph = CW'(s_axis_tdata[15:8]) + CW'(1);

    assign cur        = rd_data_reg;
    assign atlas_used = used_reg[atlas_reg];
    assign shelf_fit  = (cur.shelf_room_w >= pw_reg) && (cur.shelf_room_h >= ph_reg);
    // The width of a new shelf always suffices, as oversized glyphs never get here.
    assign below_fit  = cur.below_room_h >= ph_reg;
    assign bottom     = cur.shelf_y + ph_reg;
    assign delta      = bottom - cur.below_y;
    assign fits       = !atlas_used || shelf_fit || below_fit;
    assign can_finish = !out_valid_reg || m_axis_tready;

    // Position and new frontiers for whichever case applies.
    always_comb
    begin
        wr_data = cur;
        pos_x   = '0;
        pos_y   = '0;
        if (!atlas_used)
        begin
            wr_data.shelf_x      = pw_reg;
            wr_data.shelf_y      = '0;
            wr_data.shelf_room_w = ATLAS_W_C - pw_reg;
            wr_data.shelf_room_h = ATLAS_H_C;
            wr_data.below_y      = ph_reg;
            wr_data.below_room_h = ATLAS_H_C - ph_reg;
        end
        else if (shelf_fit)
        begin
            pos_x                = cur.shelf_x;
            pos_y                = cur.shelf_y;
            wr_data.shelf_room_w = cur.shelf_room_w - pw_reg;
            wr_data.shelf_x      = cur.shelf_x + pw_reg;
            // A glyph reaching below the remainder pushes it down.
            if (bottom > cur.below_y)
            begin
                wr_data.below_room_h = (cur.below_room_h > delta) ?
                                       (cur.below_room_h - delta) : '0;
                wr_data.below_y      = bottom;
            end
        end
        else
        begin
            pos_x                = '0;
            pos_y                = cur.below_y;
            wr_data.shelf_x      = pw_reg;
            wr_data.shelf_y      = cur.below_y;
            wr_data.shelf_room_w = ATLAS_W_C - pw_reg;
            wr_data.shelf_room_h = cur.below_room_h;
            wr_data.below_room_h = cur.below_room_h - ph_reg;
            wr_data.below_y      = cur.below_y + ph_reg;
        end
    end

    // Sequencer: next state, memory control and result formation.
    always_comb
    begin
        state_next      = state_reg;
        atlas_next      = atlas_reg;
        used_next       = used_reg;
        clear_next      = clear_reg;
        reject_next     = reject_reg;
        pw_next         = pw_reg;
        ph_next         = ph_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_placed_next = out_placed_reg;
        rd_addr         = atlas_reg;
        wr_en           = 1'b0;
        s_axis_tready   = 1'b0;

        case (state_reg)
            gasa_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                rd_addr       = '0;
                if (s_axis_tvalid)
                begin
                    atlas_next  = '0;
                    clear_next  = (s_axis_tuser == gasa_pkg::CMD_CLEAR);
                    reject_next = (in_pw > ATLAS_W_C) || (in_ph > ATLAS_H_C);
                    pw_next     = in_pw;
                    ph_next     = in_ph;
                    state_next  = gasa_pkg::ST_CHECK;
                end
            end

            gasa_pkg::ST_CHECK:
            begin
                if (clear_reg || reject_reg)
                begin
                    if (can_finish)
                    begin
                        if (clear_reg)
                        begin
                            used_next = '0;
                        end
                        out_valid_next  = 1'b1;
                        out_placed_next = 1'b0;
                        out_data_next   = '0;
                        state_next      = gasa_pkg::ST_IDLE;
                    end
                end
                else if (fits)
                begin
                    if (can_finish)
                    begin
                        wr_en                = 1'b1;
                        used_next[atlas_reg] = 1'b1;
                        out_valid_next       = 1'b1;
                        out_placed_next      = 1'b1;
                        out_data_next        = {1'b0, pos_y[9:0], pos_x[9:0],
                                                3'(atlas_reg)};
                        state_next           = gasa_pkg::ST_IDLE;
                    end
                end
                else if (atlas_reg == LAST_ATLAS)
                begin
                    if (can_finish)
                    begin
                        out_valid_next  = 1'b1;
                        out_placed_next = 1'b0;
                        out_data_next   = '0;
                        state_next      = gasa_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    // Move on to the next atlas; its entry arrives next cycle.
                    atlas_next = atlas_reg + AW'(1);
                    rd_addr    = atlas_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = gasa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gasa_pkg::ST_IDLE;
            atlas_reg     <= '0;
            used_reg      <= '0;
            clear_reg     <= 1'b0;
            reject_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            atlas_reg     <= atlas_next;
            used_reg      <= used_next;
            clear_reg     <= clear_next;
            reject_reg    <= reject_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg         <= pw_next;
        ph_reg         <= ph_next;
        out_data_reg   <= out_data_next;
        out_placed_reg <= out_placed_next;
    end

    // State memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[atlas_reg] <= wr_data;
        end
        rd_data_reg <= state_mem[rd_addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_placed_reg;

endmodule

`default_nettype wire
